// ----- hdl/assert_macros.svh -----
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// condition in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ----- hdl/rrfp_pkg.sv -----
// ---------------------------------------------------------------------------
// rrfp_pkg
// Shared types and character codes of the range request frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rrfp_pkg;

  // frame characters
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_R       = 8'h72;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // number of restoring division steps
  localparam int unsigned DIV_STEPS = 32;

  // controller states: parse phases, sticky error, divide and result hand-off
  typedef enum logic [3:0] {
    PS_HASH,
    PS_R,
    PS_COMMA,
    PS_LOSKIP,
    PS_LOW,
    PS_HISKIP,
    PS_HIGH,
    PS_TAIL,
    PS_ERROR,
    PS_DIVIDE,
    PS_FINISH
  } parse_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic num_clear;
    logic num_feed;
    logic latch_low;
    logic div_start;
    logic out_load;
    logic result_ok;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic digit_seen;
    logic bounds_ok;
    logic div_done;
    logic out_full;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hdl/rrfp_ctrl.sv -----
// ---------------------------------------------------------------------------
// rrfp_ctrl
// Frame parse state machine; sequences the divider and the result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rrfp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                in_last,
  input  wire logic [7:0]          rx_byte,
  output logic                     in_ready,
  input  wire rrfp_pkg::dp_status_t status,
  output rrfp_pkg::dp_cmd_t        cmd
);
  import rrfp_pkg::*;

  parse_state_t state, state_next;
  logic         frame_ok, frame_ok_next;
  parse_state_t phase_next;
  logic         accept;

  assign in_ready = (state != PS_DIVIDE) && (state != PS_FINISH);
  assign accept   = in_valid && in_ready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= PS_HASH;
      frame_ok <= 1'b0;
    end else begin
      state    <= state_next;
      frame_ok <= frame_ok_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next    = state;
    frame_ok_next = frame_ok;
    phase_next    = state;
    cmd           = '0;
    cmd.result_ok = frame_ok;
    case (state)
      PS_DIVIDE: begin
        if (status.div_done) begin
          state_next = PS_FINISH;
        end
      end
      PS_FINISH: begin
        if (!status.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = PS_HASH;
        end
      end
      default: begin
        if (accept) begin
          // one byte of the frame
          case (state)
            PS_HASH:  phase_next = (rx_byte == CH_HASH) ? PS_R : PS_ERROR;
            PS_R:     phase_next = (rx_byte == CH_R) ? PS_COMMA : PS_ERROR;
            PS_COMMA: begin
              if (rx_byte == CH_COMMA) begin
                phase_next    = PS_LOSKIP;
                cmd.num_clear = 1'b1;
              end else begin
                phase_next = PS_ERROR;
              end
            end
            PS_LOSKIP: begin
              if (rx_byte != CH_COLON) begin
                cmd.num_feed = 1'b1;
                phase_next   = PS_LOW;
              end
            end
            PS_LOW: begin
              if (rx_byte == CH_COLON) begin
                if (status.digit_seen) begin
                  cmd.latch_low = 1'b1;
                  cmd.num_clear = 1'b1;
                  phase_next    = PS_HISKIP;
                end else begin
                  phase_next = PS_ERROR;
                end
              end else begin
                cmd.num_feed = 1'b1;
              end
            end
            PS_HISKIP: begin
              if (rx_byte != CH_NEWLINE) begin
                cmd.num_feed = 1'b1;
                phase_next   = PS_HIGH;
              end
            end
            PS_HIGH: begin
              if (rx_byte == CH_NEWLINE) begin
                phase_next = status.digit_seen ? PS_TAIL : PS_ERROR;
              end else begin
                cmd.num_feed = 1'b1;
              end
            end
            default: phase_next = state;
          endcase
          // last byte closes the frame
          if (in_last) begin
            frame_ok_next = (phase_next == PS_TAIL) && (rx_byte == CH_NEWLINE) &&
                            status.bounds_ok;
            cmd.div_start = frame_ok_next;
            state_next    = frame_ok_next ? PS_DIVIDE : PS_FINISH;
          end else begin
            state_next = phase_next;
          end
        end
      end
    endcase
  end

  `ASSERT_NEXT(a_last_closes_frame, clk, rst, accept && in_last,
    state == PS_DIVIDE || state == PS_FINISH)
  `ASSERT_IMPLIES(a_divide_needs_bounds, clk, rst, cmd.div_start,
    status.bounds_ok && frame_ok_next)

endmodule

`default_nettype wire

// ----- hdl/rrfp_dp.sv -----
// ---------------------------------------------------------------------------
// rrfp_dp
// Decimal accumulator, bound registers, restoring divider and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rrfp_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [31:0]         random_word,
  input  wire rrfp_pkg::dp_cmd_t   cmd,
  output rrfp_pkg::dp_status_t     status,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     frame_valid,
  output logic [31:0]              drawn_value
);
  import rrfp_pkg::*;

  typedef enum logic [1:0] {NP_SPACE, NP_SIGN, NP_DIGITS, NP_DONE} num_phase_t;

  localparam logic [35:0] MAG_LIMIT = 36'h0_8000_0000;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  num_phase_t num_phase;
  logic        negative_flag;
  logic        digit_seen;
  logic [31:0] magnitude;
  logic [31:0] lower_bound;
  logic [31:0] high_value;

  logic             div_busy;
  logic [CNT_W-1:0] div_cnt;
  logic [31:0]      divisor;
  logic [31:0]      dividend;
  logic [31:0]      remainder;

  logic        is_digit, is_space, is_sign;
  logic [7:0]  digit_val;
  logic [35:0] mag_prod;
  logic [31:0] mag_sat;
  logic [32:0] rem_shift;
  logic        rem_fits;

  // character classes and the saturating times-ten step
  assign is_digit  = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign is_space  = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));
  assign is_sign   = (rx_byte == CH_PLUS) || (rx_byte == CH_MINUS);
  assign digit_val = rx_byte - CH_ZERO;
  assign mag_prod  = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0} +
                     {28'd0, digit_val};
  assign mag_sat   = (mag_prod > MAG_LIMIT) ? MAG_LIMIT[31:0] : mag_prod[31:0];

  // signed value of the token being read
  assign high_value = negative_flag ? (32'd0 - magnitude) :
                      (magnitude[31] ? 32'h7FFF_FFFF : magnitude);

  // number accumulator
  always_ff @(posedge clk) begin
    if (rst || cmd.num_clear) begin
      num_phase     <= NP_SPACE;
      negative_flag <= 1'b0;
      digit_seen    <= 1'b0;
      magnitude     <= '0;
    end else if (cmd.num_feed) begin
      case (num_phase)
        NP_SPACE: begin
          if (is_space) begin
            num_phase <= NP_SPACE;
          end else if (is_sign) begin
            negative_flag <= (rx_byte == CH_MINUS);
            num_phase     <= NP_SIGN;
          end else if (is_digit) begin
            magnitude  <= mag_sat;
            digit_seen <= 1'b1;
            num_phase  <= NP_DIGITS;
          end else begin
            num_phase <= NP_DONE;
          end
        end
        NP_SIGN, NP_DIGITS: begin
          if (is_digit) begin
            magnitude  <= mag_sat;
            digit_seen <= 1'b1;
            num_phase  <= NP_DIGITS;
          end else begin
            num_phase <= NP_DONE;
          end
        end
        default: num_phase <= num_phase;
      endcase
    end
  end

  // lower bound
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound <= '0;
    end else if (cmd.latch_low) begin
      lower_bound <= high_value;
    end
  end

  // restoring divider, one quotient bit a cycle; a zero divisor leaves the dividend
  assign rem_shift = {remainder, dividend[31]};
  assign rem_fits  = rem_shift >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_cnt  <= '0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 1'b1;
      if (div_cnt == CNT_LAST) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      divisor   <= high_value - lower_bound + 32'd1;
      dividend  <= random_word;
      remainder <= '0;
    end else if (div_busy) begin
      dividend  <= {dividend[30:0], 1'b0};
      remainder <= rem_fits ? 32'(rem_shift - {1'b0, divisor}) : rem_shift[31:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      frame_valid <= cmd.result_ok;
      drawn_value <= cmd.result_ok ? (remainder + lower_bound) : 32'd0;
    end
  end

  // status back to the controller
  always_comb begin
    status            = '0;
    status.digit_seen = digit_seen;
    status.bounds_ok  = $signed(lower_bound) <= $signed(high_value);
    status.div_done   = div_busy && (div_cnt == CNT_LAST);
    status.out_full   = out_valid && !out_ready;
  end

  `ASSERT_IMPLIES(a_load_after_divide, clk, rst, cmd.out_load, !div_busy)
  `ASSERT_NEXT(a_start_runs_divider, clk, rst, cmd.div_start, div_busy && div_cnt == '0)

endmodule

`default_nettype wire

// ----- hdl/range_request_frame_parser_top.sv -----
// Range request frame parser. Bytes of a frame "#r,<low>:<high>\n" arrive one per
// transfer on the slave side (tlast marks the final byte, which also carries the
// random word). Every byte but the last of a frame is accepted without a stall.
// The final byte of a well-formed frame starts a restoring divider that yields
// one quotient bit per cycle, so that byte occupies the block through its accept,
// 32 divide steps and the result load; the final byte of a bad frame goes from
// accept straight to the result load. A result then sits in the output register
// until taken, while the next frame's bytes are already accepted; a further frame
// end waits only if that register is still full. Result: tuser is the frame-valid
// flag, tdata the drawn value in low..high (zero for a bad frame).
// ---------------------------------------------------------------------------
// range_request_frame_parser_top
// Top level: controller and datapath of the range request frame parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module range_request_frame_parser_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // [7:0] rx_byte, [39:8] random_word
  input  wire logic        s_axis_tlast,   // end_of_frame
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] drawn_value
  output logic             m_axis_tuser    // [0] frame_valid
);
  import rrfp_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // frame parse control
  rrfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .rx_byte  (s_axis_tdata[7:0]),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // number, divider and result datapath
  rrfp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .rx_byte     (s_axis_tdata[7:0]),
    .random_word (s_axis_tdata[39:8]),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .frame_valid (m_axis_tuser),
    .drawn_value (m_axis_tdata)
  );

endmodule

`default_nettype wire
